/* design/slfr_pkg.sv */
`timescale 1ns / 1ps

package slfr_pkg;

   localparam int POOL_SIZE = 55;
   localparam int ADDR_W    = 6;
   localparam int WORD_W    = 32;

   localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(POOL_SIZE - 1);
   localparam logic [ADDR_W-1:0] SCATTER_STRIDE = 6'd21;
   localparam logic [ADDR_W:0]   SCATTER_MOD    = 7'd54;
   // Stepping 31 ahead modulo the pool size lands 24 behind, since 31 + 24 is
   // the pool size, so one partner counter serves both lags.
   localparam logic [ADDR_W-1:0] LAG_LONG       = 6'd31;
   // 1e-9 as a Q0.32 fraction, rounded to nearest.
   localparam logic [WORD_W-1:0] TINY_Q32       = 32'd4;
   localparam logic [1:0]        EXTRA_PASSES   = 2'd2;

   typedef enum logic [1:0] {
      OP_RESEED = 2'd0,
      OP_DRAW   = 2'd1,
      OP_RANGE  = 2'd2,
      OP_FLIP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic [32:0]        flip_probability;
   } req_type;

   typedef struct packed {
      logic [31:0]        fraction;
      logic signed [31:0] integer_value;
      logic               heads;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'd0,
      ST_DISPATCH   = 5'd1,
      ST_DRAW_CHK   = 5'd2,
      ST_DRAW_IDX   = 5'd3,
      ST_DRAW_READ  = 5'd4,
      ST_DRAW_MUL   = 5'd5,
      ST_DRAW_OUT   = 5'd6,
      ST_EMPTY_OUT  = 5'd7,
      ST_CLR        = 5'd8,
      ST_SEED       = 5'd9,
      ST_SCATTER    = 5'd10,
      ST_RF_INIT    = 5'd11,
      ST_RF_READ    = 5'd12,
      ST_RF_WRITE   = 5'd13,
      ST_RF_END     = 5'd14,
      ST_RF_EXIT    = 5'd15,
      ST_RESEED_OUT = 5'd16,
      ST_INIT_CLR   = 5'd17,
      ST_INIT_DONE  = 5'd18
   } step_type;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_WAIT, C_RESEED, C_DRAW,
      C_EMPTY, C_WRAP, C_J_MORE, C_PASS_MORE
   } cond_type;

   typedef enum logic [1:0] {WA_J, WA_K, WA_LAST} wa_type;
   typedef enum logic [1:0] {WD_ZERO, WD_SEED, WD_VAL, WD_DIFF} wd_type;
   typedef enum logic {RA_J, RA_IDX} ra_type;
   typedef enum logic [1:0] {J_HOLD, J_ZERO, J_ONE, J_INC} j_op_type;
   typedef enum logic [2:0] {
      K_HOLD, K_LAG, K_STRIDE, K_STRIDE_STEP, K_LAG_STEP
   } k_op_type;
   typedef enum logic [1:0] {SC_HOLD, SC_INIT, SC_STEP} sc_op_type;
   typedef enum logic [1:0] {IDX_HOLD, IDX_STEP, IDX_ZERO} idx_op_type;
   typedef enum logic [1:0] {P_HOLD, P_LOAD, P_DEC} pass_op_type;
   typedef enum logic [1:0] {OUT_NONE, OUT_DRAW, OUT_EMPTY, OUT_ZERO} out_op_type;

   typedef struct packed {
      cond_type    jcond;
      step_type    jtarget;
      logic        we;
      wa_type      wa_sel;
      wd_type      wd_sel;
      ra_type      ra_sel;
      logic        rd_en;
      j_op_type    j_op;
      k_op_type    k_op;
      sc_op_type   sc_op;
      idx_op_type  idx_op;
      pass_op_type pass_op;
      logic        mul_en;
      out_op_type  out_op;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic is_reseed;
      logic empty;
      logic wrap;
      logic j_more;
      logic pass_more;
   } status_type;

   // Control store: one word per step.
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      w = '{jcond: C_ALWAYS, jtarget: ST_IDLE, we: 1'b0, wa_sel: WA_J,
            wd_sel: WD_ZERO, ra_sel: RA_J, rd_en: 1'b0, j_op: J_HOLD,
            k_op: K_HOLD, sc_op: SC_HOLD, idx_op: IDX_HOLD, pass_op: P_HOLD,
            mul_en: 1'b0, out_op: OUT_NONE};
      unique case (s)
         ST_IDLE: begin
            w.jcond = C_WAIT; w.jtarget = ST_IDLE;
         end
         ST_DISPATCH: begin
            w.j_op = J_ZERO; w.pass_op = P_LOAD;
            w.jcond = C_RESEED; w.jtarget = ST_CLR;
         end
         ST_DRAW_CHK: begin
            w.jcond = C_EMPTY; w.jtarget = ST_EMPTY_OUT;
         end
         ST_DRAW_IDX: begin
            w.idx_op = IDX_STEP;
            w.jcond = C_WRAP; w.jtarget = ST_RF_INIT;
         end
         ST_DRAW_READ: begin
            w.ra_sel = RA_IDX; w.rd_en = 1'b1; w.jcond = C_NEVER;
         end
         ST_DRAW_MUL: begin
            w.mul_en = 1'b1; w.jcond = C_NEVER;
         end
         ST_DRAW_OUT: begin
            w.out_op = OUT_DRAW;
         end
         ST_EMPTY_OUT: begin
            w.out_op = OUT_EMPTY;
         end
         ST_CLR, ST_INIT_CLR: begin
            w.we = 1'b1; w.wa_sel = WA_J; w.wd_sel = WD_ZERO; w.j_op = J_INC;
            w.jcond = C_J_MORE; w.jtarget = s;
         end
         ST_SEED: begin
            w.we = 1'b1; w.wa_sel = WA_LAST; w.wd_sel = WD_SEED;
            w.j_op = J_ONE; w.k_op = K_STRIDE; w.sc_op = SC_INIT;
            w.jcond = C_NEVER;
         end
         ST_SCATTER: begin
            w.we = 1'b1; w.wa_sel = WA_K; w.wd_sel = WD_VAL;
            w.sc_op = SC_STEP; w.k_op = K_STRIDE_STEP; w.j_op = J_INC;
            w.jcond = C_J_MORE; w.jtarget = ST_SCATTER;
         end
         ST_RF_INIT: begin
            w.j_op = J_ZERO; w.k_op = K_LAG; w.jcond = C_NEVER;
         end
         ST_RF_READ: begin
            w.ra_sel = RA_J; w.rd_en = 1'b1; w.jcond = C_NEVER;
         end
         ST_RF_WRITE: begin
            w.we = 1'b1; w.wa_sel = WA_J; w.wd_sel = WD_DIFF;
            w.j_op = J_INC; w.k_op = K_LAG_STEP;
            w.jcond = C_J_MORE; w.jtarget = ST_RF_READ;
         end
         ST_RF_END: begin
            w.pass_op = P_DEC;
            w.jcond = C_PASS_MORE; w.jtarget = ST_RF_INIT;
         end
         ST_RF_EXIT: begin
            w.jcond = C_DRAW; w.jtarget = ST_DRAW_READ;
         end
         ST_RESEED_OUT: begin
            w.idx_op = IDX_ZERO; w.out_op = OUT_ZERO;
         end
         ST_INIT_DONE: begin
            w.j_op = J_ZERO;
         end
         default: begin
            w.jcond = C_ALWAYS; w.jtarget = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/slfr_seq.sv */
`timescale 1ns / 1ps

module slfr_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  slfr_pkg::status_type status,
   output slfr_pkg::ctrl_type   ctrl,
   output logic                 busy
);

   slfr_pkg::step_type pc_ff;
   slfr_pkg::step_type pc_in;
   logic               taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= slfr_pkg::ST_INIT_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Next step: a taken jump goes to the target, otherwise fall through.
   always_comb begin
      unique case (ctrl.jcond)
         slfr_pkg::C_NEVER:     taken = 1'b0;
         slfr_pkg::C_ALWAYS:    taken = 1'b1;
         slfr_pkg::C_WAIT:      taken = !status.start;
         slfr_pkg::C_RESEED:    taken = status.is_reseed;
         slfr_pkg::C_DRAW:      taken = !status.is_reseed;
         slfr_pkg::C_EMPTY:     taken = status.empty;
         slfr_pkg::C_WRAP:      taken = status.wrap;
         slfr_pkg::C_J_MORE:    taken = status.j_more;
         slfr_pkg::C_PASS_MORE: taken = status.pass_more;
         default:               taken = 1'b1;
      endcase
      if (taken) begin
         pc_in = ctrl.jtarget;
      end else begin
         pc_in = slfr_pkg::step_type'(pc_ff + 5'd1);
      end
   end

   always_comb begin
      ctrl = slfr_pkg::ucode(pc_ff);
      busy = (pc_ff != slfr_pkg::ST_IDLE);
   end

endmodule

/* design/subtractive_lagged_fibonacci_rng_top.sv */
`timescale 1ns / 1ps

// Subtractive lagged-Fibonacci generator over a 55-word pool of Q0.32
// fractions, run by a small microcode sequencer over one pool memory with one
// write and two registered read ports. A fraction draw or coin flip steps the
// pool index and reads one pool word; an integer draw with an empty range
// returns the low bound without reading the pool. Every 54th draw also refills
// the pool, reading and writing each pool word in turn through the memory
// ports. A reseed clears the pool, scatters the seed and runs three refill
// passes. After reset, busy stays high for a pass that clears the pool.
// Each result word appears for exactly one cycle with rsp_valid and must be
// taken then; csr_data may be written only while busy is low.
module subtractive_lagged_fibonacci_rng_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  slfr_pkg::req_type req_data,
   output logic              rsp_valid,
   output slfr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   localparam int AW = slfr_pkg::ADDR_W;
   localparam int WW = slfr_pkg::WORD_W;

   slfr_pkg::ctrl_type   ctrl;
   slfr_pkg::status_type status;

   logic [WW-1:0] pool_mem [slfr_pkg::POOL_SIZE];

   logic [WW-1:0]      seed_ff;
   slfr_pkg::req_type  req_ff;
   logic [32:0]        span_ff;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [1:0]         pass_ff, pass_in;
   logic [WW-1:0]      val_ff, val_in;
   logic [WW-1:0]      prv_ff, prv_in;
   logic [WW-1:0]      rda_ff, rdb_ff;
   logic [WW-1:0]      prod_ff;
   logic               rsp_valid_ff;
   slfr_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic          accept;
   logic [AW-1:0] wa, ra;
   logic [WW-1:0] wd;
   logic [AW:0]   k_stride_sum;
   logic [64:0]   prod_full;
   logic [33:0]   range_sum;
   logic [33:0]   range_top;

   slfr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      status.start     = start;
      status.is_reseed = (req_ff.operation == slfr_pkg::OP_RESEED);
      status.empty     = (req_ff.operation == slfr_pkg::OP_RANGE) &&
                         (req_ff.range_low >= req_ff.range_high);
      status.wrap      = (idx_ff == slfr_pkg::LAST_ADDR);
      status.j_more    = (j_ff != slfr_pkg::LAST_ADDR);
      status.pass_more = (pass_ff != 2'd0);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         j_ff         <= '0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_data;
         end
         j_ff         <= j_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= (ctrl.out_op != slfr_pkg::OUT_NONE);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         span_ff <= {req_data.range_high[31], req_data.range_high}
                    - {req_data.range_low[31], req_data.range_low} + 33'd1;
      end
      k_ff   <= k_in;
      val_ff <= val_in;
      prv_ff <= prv_in;
      if (ctrl.mul_en) begin
         prod_ff <= prod_full[63:32];
      end
      if (ctrl.out_op != slfr_pkg::OUT_NONE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Pool memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         pool_mem[wa] <= wd;
      end
      if (ctrl.rd_en) begin
         rda_ff <= pool_mem[ra];
         rdb_ff <= pool_mem[k_ff];
      end
   end

   always_comb begin
      case (ctrl.wa_sel)
         slfr_pkg::WA_J:    wa = j_ff;
         slfr_pkg::WA_K:    wa = k_ff;
         slfr_pkg::WA_LAST: wa = slfr_pkg::LAST_ADDR;
         default:           wa = j_ff;
      endcase
      case (ctrl.wd_sel)
         slfr_pkg::WD_ZERO: wd = '0;
         slfr_pkg::WD_SEED: wd = seed_ff;
         slfr_pkg::WD_VAL:  wd = val_ff;
         slfr_pkg::WD_DIFF: wd = rda_ff - rdb_ff;
         default:           wd = '0;
      endcase
      ra = (ctrl.ra_sel == slfr_pkg::RA_IDX) ? idx_ff : j_ff;
   end

   always_comb begin
      case (ctrl.j_op)
         slfr_pkg::J_ZERO: j_in = '0;
         slfr_pkg::J_ONE:  j_in = AW'(1);
         slfr_pkg::J_INC:  j_in = j_ff + AW'(1);
         default:          j_in = j_ff;
      endcase

      // Scatter address steps by 21 mod 54; refill partner steps mod 55.
      k_stride_sum = {1'b0, k_ff} + {1'b0, slfr_pkg::SCATTER_STRIDE};
      case (ctrl.k_op)
         slfr_pkg::K_LAG:    k_in = slfr_pkg::LAG_LONG;
         slfr_pkg::K_STRIDE: k_in = slfr_pkg::SCATTER_STRIDE;
         slfr_pkg::K_STRIDE_STEP: begin
            if (k_stride_sum >= slfr_pkg::SCATTER_MOD) begin
               k_in = AW'(k_stride_sum - slfr_pkg::SCATTER_MOD);
            end else begin
               k_in = k_stride_sum[AW-1:0];
            end
         end
         slfr_pkg::K_LAG_STEP: begin
            k_in = (k_ff == slfr_pkg::LAST_ADDR) ? '0 : k_ff + AW'(1);
         end
         default: k_in = k_ff;
      endcase

      case (ctrl.sc_op)
         slfr_pkg::SC_INIT: begin
            val_in = slfr_pkg::TINY_Q32;
            prv_in = seed_ff;
         end
         slfr_pkg::SC_STEP: begin
            val_in = prv_ff - val_ff;
            prv_in = val_ff;
         end
         default: begin
            val_in = val_ff;
            prv_in = prv_ff;
         end
      endcase

      case (ctrl.idx_op)
         slfr_pkg::IDX_STEP: begin
            idx_in = (idx_ff == slfr_pkg::LAST_ADDR) ? AW'(1) : idx_ff + AW'(1);
         end
         slfr_pkg::IDX_ZERO: idx_in = '0;
         default:            idx_in = idx_ff;
      endcase

      case (ctrl.pass_op)
         slfr_pkg::P_LOAD: begin
            pass_in = (req_ff.operation == slfr_pkg::OP_RESEED) ?
                      slfr_pkg::EXTRA_PASSES : 2'd0;
         end
         slfr_pkg::P_DEC: pass_in = pass_ff - 2'd1;
         default:         pass_in = pass_ff;
      endcase
   end

   // Result: low + floor(draw * span / 2^32), clamped to high.
   always_comb begin
      prod_full = 65'(rda_ff) * 65'(span_ff);
      range_sum = {{2{req_ff.range_low[31]}}, req_ff.range_low} + {2'b00, prod_ff};
      range_top = {{2{req_ff.range_high[31]}}, req_ff.range_high};
      rsp_data_in = '0;
      case (ctrl.out_op)
         slfr_pkg::OUT_DRAW: begin
            rsp_data_in.fraction = rda_ff;
            if (req_ff.operation == slfr_pkg::OP_RANGE) begin
               if ($signed(range_sum) > $signed(range_top)) begin
                  rsp_data_in.integer_value = req_ff.range_high;
               end else begin
                  rsp_data_in.integer_value = range_sum[31:0];
               end
            end
            if (req_ff.operation == slfr_pkg::OP_FLIP) begin
               rsp_data_in.heads = ({1'b0, rda_ff} <= req_ff.flip_probability);
            end
         end
         slfr_pkg::OUT_EMPTY: begin
            rsp_data_in.integer_value = req_ff.range_low;
         end
         default: rsp_data_in = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/slfr_checker.sv */
`timescale 1ns / 1ps

module slfr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input slfr_pkg::rsp_type rsp_data
);

   // An accepted word always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A result word only follows a cycle of work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without preceding work");

   // Each output step is followed by a step without output, so strobes never touch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // Heads comes only from a coin flip, which carries no integer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.heads |-> rsp_data.integer_value == 32'sd0)
      else $error("heads reported together with an integer");

endmodule

bind subtractive_lagged_fibonacci_rng_top slfr_checker u_slfr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
